[sv/qvr_pkg.sv]
// Package for the quaternion vector rotation pipeline.
// Holds the field widths, the fixed-point constants and the stage payload types.
// No dependencies.
package qvr_pkg;

  // Field widths and fixed-point format.
  localparam int VEC_BITS       = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int QUAT_WIDTH     = 16;

  // Derived widths of the datapath.
  localparam int PROD_W  = 2 * QUAT_WIDTH;       // quaternion component product
  localparam int TERM_W  = PROD_W + 1;           // half matrix term, sum of two products
  localparam int MAC_W   = VEC_BITS + TERM_W;    // vector component times matrix term
  localparam int SUM_W   = MAC_W + 2;            // row sum of three products
  localparam int SHIFT   = 2 * QUAT_FRAC_BITS - 1;
  localparam int ROW_W   = SUM_W + 1;            // scaled row plus vector component
  localparam int IN_W    = 3 * VEC_BITS + 4 * QUAT_WIDTH;
  localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = 3 * VEC_BITS;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  typedef logic [VEC_BITS-1:0]         vec_t;
  typedef logic [2:0][VEC_BITS-1:0]    vec3_t;
  typedef logic [QUAT_WIDTH-1:0]       quat_t;
  typedef logic [PROD_W-1:0]           prod_t;
  typedef logic [2:0][2:0][TERM_W-1:0] mat_t;
  typedef logic [2:0][2:0][MAC_W-1:0]  mac_t;
  typedef logic [2:0][SUM_W-1:0]       row_sum_t;

  // Input item as packed on the slave bus; vec_x sits in the lowest bits.
  typedef struct packed {
    quat_t quat_z;
    quat_t quat_y;
    quat_t quat_x;
    quat_t quat_w;
    vec_t  vec_z;
    vec_t  vec_y;
    vec_t  vec_x;
  } in_item_t;

  // Products of quaternion component pairs.
  typedef struct packed {
    prod_t xx;
    prod_t yy;
    prod_t zz;
    prod_t xy;
    prod_t xz;
    prod_t yz;
    prod_t wx;
    prod_t wy;
    prod_t wz;
  } quat_prod_t;

  typedef struct packed {
    vec3_t      vec;
    quat_prod_t prod;
  } prod_stage_t;

  typedef struct packed {
    vec3_t vec;
    mat_t  term;
  } mat_stage_t;

  typedef struct packed {
    vec3_t vec;
    mac_t  mac;
  } mac_stage_t;

  typedef struct packed {
    vec3_t    vec;
    row_sum_t sum;
  } sum_stage_t;

  typedef struct packed {
    vec3_t rot;
    logic  saturated;
  } out_item_t;

  // Sign-extends a component product to the width of a matrix term.
  function automatic logic [TERM_W-1:0] term_ext(input prod_t p);
    term_ext = {p[PROD_W-1], p};
  endfunction

  // Sign-extends a vector-times-term product to the row sum width.
  function automatic logic [SUM_W-1:0] sum_ext(input logic [MAC_W-1:0] m);
    sum_ext = {{(SUM_W-MAC_W){m[MAC_W-1]}}, m};
  endfunction

endpackage

[sv/qvr_matrix.sv]
// Matrix stages of the rotation pipeline: quaternion pair products, then the
// halves of the off-identity rotation matrix terms. Depends on qvr_pkg.
module qvr_matrix (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qvr_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qvr_pkg::mat_stage_t  out_data
);
  import qvr_pkg::*;

  logic        prod_valid;
  logic        prod_ready;
  prod_stage_t prod;
  quat_prod_t  prod_next;
  logic        term_ready;
  mat_t        term_next;
  logic signed [QUAT_WIDTH-1:0] qw, qx, qy, qz;

  // Nine signed products of quaternion components.
  always_comb begin
    qw = $signed(in_data.quat_w);
    qx = $signed(in_data.quat_x);
    qy = $signed(in_data.quat_y);
    qz = $signed(in_data.quat_z);
    prod_next.xx = PROD_W'(qx * qx);
    prod_next.yy = PROD_W'(qy * qy);
    prod_next.zz = PROD_W'(qz * qz);
    prod_next.xy = PROD_W'(qx * qy);
    prod_next.xz = PROD_W'(qx * qz);
    prod_next.yz = PROD_W'(qy * qz);
    prod_next.wx = PROD_W'(qw * qx);
    prod_next.wy = PROD_W'(qw * qy);
    prod_next.wz = PROD_W'(qw * qz);
  end

  assign prod_ready = !prod_valid || term_ready;
  assign in_ready   = prod_ready;

  // Product stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= in_valid;
    end
    if (prod_ready && in_valid) begin
      prod.vec  <= {in_data.vec_z, in_data.vec_y, in_data.vec_x};
      prod.prod <= prod_next;
    end
  end

  // Half matrix terms: diagonal without the identity, off-diagonal pairs.
  always_comb begin
    term_next[0][0] = '0 - (term_ext(prod.prod.yy) + term_ext(prod.prod.zz));
    term_next[0][1] = term_ext(prod.prod.xy) - term_ext(prod.prod.wz);
    term_next[0][2] = term_ext(prod.prod.xz) + term_ext(prod.prod.wy);
    term_next[1][0] = term_ext(prod.prod.xy) + term_ext(prod.prod.wz);
    term_next[1][1] = '0 - (term_ext(prod.prod.xx) + term_ext(prod.prod.zz));
    term_next[1][2] = term_ext(prod.prod.yz) - term_ext(prod.prod.wx);
    term_next[2][0] = term_ext(prod.prod.xz) - term_ext(prod.prod.wy);
    term_next[2][1] = term_ext(prod.prod.yz) + term_ext(prod.prod.wx);
    term_next[2][2] = '0 - (term_ext(prod.prod.xx) + term_ext(prod.prod.yy));
  end

  assign term_ready = !out_valid || out_ready;

  // Matrix term stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (term_ready) begin
      out_valid <= prod_valid;
    end
    if (term_ready && prod_valid) begin
      out_data.vec  <= prod.vec;
      out_data.term <= term_next;
    end
  end

endmodule

[sv/qvr_mac.sv]
// Multiply-accumulate stages: vector components times matrix terms, then the
// three-way row sums with the rounding half added. Depends on qvr_pkg.
module qvr_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qvr_pkg::mat_stage_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qvr_pkg::sum_stage_t  out_data
);
  import qvr_pkg::*;

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (SHIFT - 1);

  logic       mac_valid;
  logic       mac_ready;
  mac_stage_t mac;
  mac_t       mac_next;
  logic       sum_ready;
  row_sum_t   sum_next;

  // One signed product per matrix entry.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        mac_next[r][j] = MAC_W'($signed(in_data.vec[j]) * $signed(in_data.term[r][j]));
      end
    end
  end

  assign mac_ready = !mac_valid || sum_ready;
  assign in_ready  = mac_ready;

  // Product stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_valid <= 1'b0;
    end else if (mac_ready) begin
      mac_valid <= in_valid;
    end
    if (mac_ready && in_valid) begin
      mac.vec <= in_data.vec;
      mac.mac <= mac_next;
    end
  end

  // Exact row sums, biased by one half of the final scale for rounding.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_next[r] = sum_ext(mac.mac[r][0]) + sum_ext(mac.mac[r][1])
                  + sum_ext(mac.mac[r][2]) + ROUND_HALF;
    end
  end

  assign sum_ready = !out_valid || out_ready;

  // Row sum stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sum_ready) begin
      out_valid <= mac_valid;
    end
    if (sum_ready && mac_valid) begin
      out_data.vec <= mac.vec;
      out_data.sum <= sum_next;
    end
  end

endmodule

[sv/qvr_round.sv]
// Output stage: scales each row sum down, adds the identity part and
// saturates to the vector width. Depends on qvr_pkg.
module qvr_round (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qvr_pkg::sum_stage_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qvr_pkg::out_item_t   out_data
);
  import qvr_pkg::*;

  localparam logic [ROW_W-1:0] ROW_MAX = {{(ROW_W-VEC_BITS+1){1'b0}}, {(VEC_BITS-1){1'b1}}};
  localparam logic [ROW_W-1:0] ROW_MIN = {{(ROW_W-VEC_BITS+1){1'b1}}, {(VEC_BITS-1){1'b0}}};

  logic [2:0][SUM_W-1:0] scaled;
  logic [2:0][ROW_W-1:0] row;
  logic [2:0]            clip;
  out_item_t             out_next;

  // Floor shift of the biased sum rounds to nearest, half toward plus infinity.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      scaled[r] = SUM_W'($signed(in_data.sum[r]) >>> SHIFT);
      row[r]    = {scaled[r][SUM_W-1], scaled[r]}
                + {{(ROW_W-VEC_BITS){in_data.vec[r][VEC_BITS-1]}}, in_data.vec[r]};
      if ($signed(row[r]) > $signed(ROW_MAX)) begin
        out_next.rot[r] = ROW_MAX[VEC_BITS-1:0];
        clip[r] = 1'b1;
      end else if ($signed(row[r]) < $signed(ROW_MIN)) begin
        out_next.rot[r] = ROW_MIN[VEC_BITS-1:0];
        clip[r] = 1'b1;
      end else begin
        out_next.rot[r] = row[r][VEC_BITS-1:0];
        clip[r] = 1'b0;
      end
    end
    out_next.saturated = |clip;
  end

  assign in_ready = !out_valid || out_ready;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= out_next;
    end
  end

endmodule

[sv/quaternion_vector_rotate.sv]
// Top level of the quaternion vector rotation pipeline.
// Depends on qvr_pkg, qvr_matrix, qvr_mac and qvr_round.
//
//   channel | direction | tdata (low bit up)                              | tuser
//   s_*     | in        | vec_x vec_y vec_z quat_w quat_x quat_y quat_z    | none
//   m_*     | out       | rot_x rot_y rot_z                                | saturated
//
// One transaction enters per cycle while the output is not stalled; results pass
// through two matrix stages, two multiply-accumulate stages and one output register.
// Each stage holds its own valid bit and takes new data whenever it is empty
// or its successor moves, so bubbles close up under output back-pressure.
// Reset clears all valid bits; no input is taken while reset is high.
module quaternion_vector_rotate (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z (16 bits each)
  input  logic [qvr_pkg::IN_BYTES_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // rot_x, rot_y, rot_z (16 bits each)
  output logic [qvr_pkg::OUT_BYTES_W-1:0] m_tdata,
  // saturated
  output logic                            m_tuser
);
  import qvr_pkg::*;

  in_item_t    in_item;
  logic        mat_in_ready;
  logic        mat_valid;
  logic        mat_ready;
  mat_stage_t  mat;
  logic        sum_valid;
  logic        sum_ready;
  sum_stage_t  sum;
  out_item_t   result;

  assign in_item  = in_item_t'(s_tdata[IN_W-1:0]);
  assign s_tready = mat_in_ready && !rst;

  qvr_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid && !rst),
    .in_ready  (mat_in_ready),
    .in_data   (in_item),
    .out_valid (mat_valid),
    .out_ready (mat_ready),
    .out_data  (mat)
  );

  qvr_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mat_valid),
    .in_ready  (mat_ready),
    .in_data   (mat),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_data  (sum)
  );

  qvr_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_data   (sum),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (result)
  );

  // Output packing, zero fill up to whole bytes.
  assign m_tdata = OUT_BYTES_W'(result.rot);
  assign m_tuser = result.saturated;

endmodule

[sv/qvr_checker.sv]
// Port-level checker for the quaternion vector rotation pipeline, with its bind.
// Depends on qvr_pkg and quaternion_vector_rotate.
module qvr_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tready,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [qvr_pkg::OUT_BYTES_W-1:0] m_tdata,
  input  logic                            m_tuser
);
  import qvr_pkg::*;

  localparam logic [VEC_BITS-1:0] VMAX = {1'b0, {(VEC_BITS-1){1'b1}}};
  localparam logic [VEC_BITS-1:0] VMIN = {1'b1, {(VEC_BITS-1){1'b0}}};

  logic [2:0][VEC_BITS-1:0] rot;
  logic                     any_limit;

  assign rot = m_tdata[OUT_W-1:0];
  assign any_limit = (rot[0] == VMAX) || (rot[0] == VMIN) || (rot[1] == VMAX)
                  || (rot[1] == VMIN) || (rot[2] == VMAX) || (rot[2] == VMIN);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result transaction dropped while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // An empty or draining output stage never blocks the input.
  a_no_idle_block: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input blocked while the pipeline can move");

  // The saturation flag only comes with a clipped component.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> any_limit)
    else $error("saturated set without a component at the limit");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
